[hdl/qbf_pkg.sv]
// Shared types and constants for the quadratic Bezier through-point fit unit.
// Depends on nothing; every file of the block but qbf_checker imports it.
`timescale 1ns / 1ps
`default_nettype none

package qbf_pkg;

	// Width of the cubic coefficients handed from the front to the back.
	localparam int CW = 72;
	// Width of the bisection working values and their sums.
	localparam int SW = 76;
	// Width of the control point numerator, signed.
	localparam int NW = 84;
	// Width of the control point divisor.
	localparam int DW = 50;
	// Width of the curve parameter, unsigned Q1.24.
	localparam int TW = 25;
	// Fraction bits of the internal parameter accumulator.
	localparam int TFRAC = 48;
	// Shift that lines up the parameter square halves in the numerator.
	localparam int HALF_SHIFT = 24;

	typedef struct packed {
		logic signed [CW-1:0] d;
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] b;
		logic signed [CW-1:0] a;
		logic [2:0][31:0]     p0;
		logic [2:0][31:0]     p1;
		logic [2:0][31:0]     p2;
	} qbf_job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MAC,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_BISECT,
		B_PREP,
		B_MAC,
		B_DIV,
		B_ROUND,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

[hdl/qbf_front.sv]
// Front part: accepts a point triple and builds the scaled Bernstein cubic.
// Uses qbf_pkg; three dot products run through one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module qbf_front import qbf_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [287:0]   s_tdata,
	output logic                push_valid,
	input  wire logic           push_ready,
	output qbf_job_t            push_job
);

	front_state_t state_q, state_n;
	logic [2:0][31:0] p0_q, p1_q, p2_q;
	logic [1:0] ax_q, grp_q;
	logic signed [CW-1:0] vv_q, vw_q, ww_q;
	logic signed [32:0] v0, v2, opa, opb;
	logic signed [65:0] prod;
	logic last_mac;

	always_comb begin
		v0 = 33'(signed'(p0_q[ax_q])) - 33'(signed'(p1_q[ax_q]));
		v2 = 33'(signed'(p2_q[ax_q])) - 33'(signed'(p1_q[ax_q]));
		opa = (grp_q == 2'd2) ? v2 : v0;
		opb = (grp_q == 2'd0) ? v0 : v2;
		prod = opa * opb;
		last_mac = (ax_q == 2'd2) && (grp_q == 2'd2);
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			F_IDLE: if (s_tvalid) state_n = F_MAC;
			F_MAC:  if (last_mac) state_n = F_PUSH;
			F_PUSH: if (push_ready) state_n = F_IDLE;
			default: state_n = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == F_IDLE);
		push_valid = (state_q == F_PUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			p0_q <= s_tdata[95:0];
			p1_q <= s_tdata[191:96];
			p2_q <= s_tdata[287:192];
			ax_q <= 2'd0;
			grp_q <= 2'd0;
			vv_q <= '0;
			vw_q <= '0;
			ww_q <= '0;
		end else if (state_q == F_MAC) begin
			unique case (grp_q)
				2'd0: vv_q <= vv_q + CW'(prod);
				2'd1: vw_q <= vw_q + CW'(prod);
				default: ww_q <= ww_q + CW'(prod);
			endcase
			if (ax_q == 2'd2) begin
				ax_q <= 2'd0;
				grp_q <= grp_q + 2'd1;
			end else begin
				ax_q <= ax_q + 2'd1;
			end
		end
	end

	// The cubic is kept scaled by three: (-3 v0.v0, -v0.v2, v0.v2, 3 v2.v2).
	always_comb begin
		push_job.d = -(vv_q + (vv_q <<< 1));
		push_job.c = -vw_q;
		push_job.b = vw_q;
		push_job.a = ww_q + (ww_q <<< 1);
		push_job.p0 = p0_q;
		push_job.p1 = p1_q;
		push_job.p2 = p2_q;
	end

endmodule

`default_nettype wire

[hdl/qbf_queue.sv]
// Two-entry job queue between the front and the back part.
// Uses qbf_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module qbf_queue import qbf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire qbf_job_t push_job,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output qbf_job_t      pop_job
);

	qbf_job_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_job = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

[hdl/qbf_back.sv]
// Back part: bisects the cubic for t, builds the control point numerators and
// divides them bit-serially; holds the result in the output register. Uses qbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbf_back import qbf_pkg::*; #(
	parameter int MAX_ITERATIONS = 24
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [31:0]  root_tolerance,
	input  wire logic         pop_valid,
	output logic              pop_ready,
	input  wire qbf_job_t     pop_job,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,
	output logic              m_tuser
);

	localparam int IW = $clog2(MAX_ITERATIONS + 1);
	localparam int NCW = $clog2(NW);

	back_state_t state_q, state_n;
	logic signed [SW-1:0] d_q, c_q, b_q, a_q;
	logic [2:0][31:0] p0_q, p1_q, p2_q;
	logic [IW-1:0] it_q;
	// One bit above the fraction so that t can reach exactly one.
	logic [TFRAC:0] t48_q;
	logic [TW-1:0] tq_q;
	logic [48:0] uu_q, tt_q;
	logic [DW-1:0] den_q, rem_q;
	logic signed [NW-1:0] acc_q;
	logic [NW-1:0] mag_q, quo_q;
	logic neg_q, numz_q, flag_q;
	logic [1:0] ax_q, st_q;
	logic [NCW-1:0] dcnt_q;
	logic [2:0][31:0] ctl_q;
	logic out_valid_q;

	// Bisection step.
	logic signed [SW-1:0] tol3, sum, m, lc, lb, rc, rb, mlo, mhi;
	logic go_left, go_right, cap, stop;
	logic [5:0] sh;
	logic [TFRAC:0] bit_t;

	always_comb begin
		tol3 = SW'({2'b00, root_tolerance}) + SW'({1'b0, root_tolerance, 1'b0});
		sum = d_q + (c_q + (c_q <<< 1)) + (b_q + (b_q <<< 1)) + a_q;
		m = sum >>> 3;
		mlo = m - tol3;
		mhi = m + tol3;
		go_left = !mlo[SW-1];
		go_right = mhi[SW-1] || (mhi == '0);
		lc = (d_q + c_q) >>> 1;
		lb = (d_q + (c_q <<< 1) + b_q) >>> 2;
		rc = (c_q + (b_q <<< 1) + a_q) >>> 2;
		rb = (b_q + a_q) >>> 1;
		cap = (it_q == IW'(MAX_ITERATIONS));
		stop = cap || (!go_left && !go_right);
		sh = 6'(TFRAC - 1) - 6'(it_q);
		bit_t = (TFRAC + 1)'(1) << sh;
	end

	// Shared 25x25 multiplier for t squares and the divisor.
	logic [TW-1:0] tq_c, u, pa, pb;
	logic [TFRAC:0] t_rnd;
	logic [2*TW-1:0] pprod;

	always_comb begin
		t_rnd = t48_q + (TFRAC + 1)'(1 << (HALF_SHIFT - 1));
		tq_c = t_rnd[TFRAC:HALF_SHIFT];
		u = TW'(1 << HALF_SHIFT) - tq_q;
		pa = (st_q == 2'd2) ? tq_q : u;
		pb = (st_q[1]) ? tq_q : u;
		pprod = pa * pb;
	end

	// Numerator multiply-accumulate: 25 by 32 bits a cycle.
	logic signed [TW:0] ma;
	logic signed [31:0] mb;
	logic signed [TW+32:0] mprod;
	logic signed [NW-1:0] term, acc_n;

	always_comb begin
		unique case (st_q)
			2'd0: ma = {1'b0, uu_q[48:24]};
			2'd1: ma = {2'b00, uu_q[23:0]};
			2'd2: ma = {1'b0, tt_q[48:24]};
			default: ma = {2'b00, tt_q[23:0]};
		endcase
		mb = (st_q[1]) ? signed'(p2_q[ax_q]) : signed'(p0_q[ax_q]);
		mprod = ma * mb;
		term = st_q[0] ? NW'(mprod) : (NW'(mprod) <<< HALF_SHIFT);
		acc_n = ((st_q == 2'd0) ? (NW'(signed'(p1_q[ax_q])) <<< TFRAC) : acc_q) - term;
	end

	// Restoring divide step and final rounding.
	logic [DW:0] rem_sh;
	logic take;
	logic [NW-1:0] qr, limit;
	logic over;
	logic [31:0] val, res;

	always_comb begin
		rem_sh = {rem_q, mag_q[NW-1]};
		take = (rem_sh >= (DW + 1)'(den_q));
		qr = quo_q + NW'(rem_q >= (den_q - rem_q));
		limit = neg_q ? NW'(33'h080000000) : NW'(33'h07fffffff);
		over = (qr > limit);
		val = over ? limit[31:0] : qr[31:0];
		if (den_q == '0) val = numz_q ? 32'd0 : limit[31:0];
		res = neg_q ? (32'd0 - val) : val;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			B_IDLE:   if (pop_valid) state_n = B_BISECT;
			B_BISECT: if (stop) state_n = B_PREP;
			B_PREP:   if (st_q == 2'd3) state_n = B_MAC;
			B_MAC:    if (st_q == 2'd3) state_n = (den_q == '0) ? B_ROUND : B_DIV;
			B_DIV:    if (dcnt_q == '0) state_n = B_ROUND;
			B_ROUND:  state_n = (ax_q == 2'd2) ? B_DONE : B_MAC;
			B_DONE:   if (!out_valid_q || m_tready) state_n = B_IDLE;
			default:  state_n = B_IDLE;
		endcase
	end

	logic load_out;
	always_comb begin
		pop_ready = (state_q == B_IDLE);
		load_out = (state_q == B_DONE) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				d_q <= SW'(pop_job.d);
				c_q <= SW'(pop_job.c);
				b_q <= SW'(pop_job.b);
				a_q <= SW'(pop_job.a);
				p0_q <= pop_job.p0;
				p1_q <= pop_job.p1;
				p2_q <= pop_job.p2;
				it_q <= '0;
				t48_q <= '0;
				flag_q <= 1'b0;
				st_q <= 2'd0;
				ax_q <= 2'd0;
			end
			B_BISECT: begin
				// Stopping or hitting the cap adds the current half width once more,
				// leaving t at the midpoint of the interval reached.
				if (stop) begin
					t48_q <= t48_q + bit_t;
				end else if (go_left) begin
					c_q <= lc;
					b_q <= lb;
					a_q <= m;
				end else begin
					d_q <= m;
					c_q <= rc;
					b_q <= rb;
					t48_q <= t48_q + bit_t;
				end
				it_q <= it_q + IW'(1);
			end
			B_PREP: begin
				unique case (st_q)
					2'd0: tq_q <= tq_c;
					2'd1: uu_q <= pprod[48:0];
					2'd2: tt_q <= pprod[48:0];
					default: den_q <= {pprod[48:0], 1'b0};
				endcase
				st_q <= st_q + 2'd1;
			end
			B_MAC: begin
				acc_q <= acc_n;
				st_q <= st_q + 2'd1;
				if (st_q == 2'd3) begin
					neg_q <= acc_n[NW-1];
					numz_q <= (acc_n == '0);
					mag_q <= acc_n[NW-1] ? NW'(-acc_n) : NW'(acc_n);
					rem_q <= '0;
					quo_q <= '0;
					dcnt_q <= NCW'(NW - 1);
				end
			end
			B_DIV: begin
				rem_q <= take ? DW'(rem_sh - (DW + 1)'(den_q)) : DW'(rem_sh);
				quo_q <= {quo_q[NW-2:0], take};
				mag_q <= mag_q << 1;
				dcnt_q <= dcnt_q - NCW'(1);
			end
			B_ROUND: begin
				ctl_q[ax_q] <= res;
				if ((den_q == '0) || over) flag_q <= 1'b1;
				ax_q <= ax_q + 2'd1;
				st_q <= 2'd0;
			end
			default: begin
				if (load_out) begin
					m_tdata <= {7'd0, tq_q, ctl_q[2], ctl_q[1], ctl_q[0]};
					m_tuser <= flag_q;
				end
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

[hdl/quadratic_bezier_through_point_fit_unit.sv]
// Top level of the quadratic Bezier through-point fit unit.
// Uses qbf_pkg, qbf_front, qbf_queue and qbf_back.
//
// Each input beat carries three Q16.16 points; one output beat returns the
// control point, the parameter t in Q1.24 and a degenerate flag. The front
// takes a beat, forms the dot products through one multiplier and passes
// the cubic through a two-entry queue to the back. The back runs one
// bisection step per cycle, then forms t, the t squares and the divisor,
// and for each axis runs the numerator multiply-accumulate, a restoring
// divide over the 84 numerator bits (skipped on a zero divisor) and a round
// step. The front accepts the next beat while the back works and the queue
// has room, and the output register holds a result while the next one is
// computed.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_bezier_through_point_fit_unit import qbf_pkg::*; #(
	parameter int MAX_ITERATIONS = 24,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data,    // root_tolerance
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// first_x, first_y, first_z, middle_x, middle_y, middle_z, last_x, last_y, last_z
	input  wire logic [287:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// control_x, control_y, control_z, curve_param, zero pad
	output logic [127:0]      m_tdata,
	output logic              m_tuser      // degenerate
);

	localparam logic [63:0] TOL_WIDE =
		((64'd1 << (2 * FRACTION_BITS)) + 64'd500000) / 64'd1000000;
	localparam logic [31:0] TOL_RESET = TOL_WIDE[31:0];

	logic [31:0] tol_q;
	logic f_valid, f_ready, q_valid, q_ready;
	qbf_job_t f_job, q_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	qbf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.push_valid(f_valid), .push_ready(f_ready), .push_job(f_job)
	);

	qbf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_job(f_job),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_job(q_job)
	);

	qbf_back #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_back (
		.clk(clk), .arst_n(arst_n), .root_tolerance(tol_q),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_job(q_job),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

`default_nettype wire

[hdl/qbf_checker.sv]
// Port-level checks for the quadratic Bezier through-point fit unit.
// Bound to the top level; depends on its port names only.
`timescale 1ns / 1ps
`default_nettype none

module qbf_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         cfg_valid,
	input wire logic         cfg_ready,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata,
	input wire logic         m_tuser
);

	// A result held back by the sink keeps its beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// The front is busy with the dot products right after it takes a beat.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken twice in a row");

	// t never exceeds one.
	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[120] && (m_tdata[119:96] != 24'd0)))
		else $error("curve parameter above one");

	// t at either end gives a zero divisor, which must raise the flag.
	a_end_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[120:96] == 25'd0) || (m_tdata[120:96] == 25'h1000000))
		|-> m_tuser)
		else $error("zero divisor without degenerate flag");

endmodule

bind quadratic_bezier_through_point_fit_unit qbf_checker u_qbf_checker (.*);

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the quadratic Bezier through-point fit unit.
// Needs qbf_pkg and quadratic_bezier_through_point_fit_unit; a built-in predictor checks each beat.
`timescale 1ns / 1ps

module testbench;
	import qbf_pkg::*;

	localparam int MAX_IT = 24;
	localparam int N_RANDOM = 680;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [31:0] TOL_DEFAULT = 32'd4295;
	localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] NEG_MAX = 32'sh8000_0000;
	localparam logic [24:0] T_ONE = 25'h100_0000;
	localparam logic [24:0] T_HALF = 25'h080_0000;

	typedef struct packed {
		logic signed [31:0] cx, cy, cz;
		logic [24:0] t;
		logic degen;
	} fit_t;

	typedef struct {
		logic [287:0] pts;
		bit known;
		fit_t res;
	} row_t;

	logic clk = 0, arst_n = 0;
	logic cfg_valid = 0, s_tvalid = 0, m_tready = 0;
	logic [31:0] cfg_data = '0;
	logic [287:0] s_tdata = '0;
	logic cfg_ready, s_tready, m_tvalid, m_tuser;
	logic [127:0] m_tdata;

	logic [31:0] tolerance = TOL_DEFAULT;
	fit_t expected_fits[$];
	int mismatches = 0, fits_seen = 0, idle_cycles = 0;
	bit recv_hold = 0, recv_noidle = 0, send_noidle = 0;
	int degen_count = 0, cap_count = 0;

	always #4 clk = ~clk;

	quadratic_bezier_through_point_fit_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic logic signed [127:0] sar(logic signed [127:0] v, int k);
		return v >>> k;
	endfunction

	// Rounded, saturated divide of one axis; sets degen on saturation or zero divisor.
	function automatic logic signed [31:0] divide_axis(logic signed [127:0] num,
			logic [63:0] den, inout logic degen);
		logic [127:0] mag, q, r;
		logic neg;
		logic [127:0] lim;
		neg = num < 0;
		mag = neg ? -num : num;
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (den == 0) begin
			degen = 1;
			return num == 0 ? 32'sd0 : (neg ? NEG_MAX : POS_MAX);
		end
		q = mag / den;
		r = mag % den;
		if (r >= den - r) q = q + 1;
		if (q > lim) begin
			degen = 1;
			q = lim;
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic fit_t predict_fit(logic [287:0] pts);
		logic signed [63:0] p0[3], p1[3], p2[3], v0[3], v2[3];
		logic signed [127:0] d, c, b, a, m, tol3, vv0, vv2, v02, num;
		logic [63:0] t48, half, tq, u, den;
		fit_t f;
		bit stopped;
		for (int i = 0; i < 3; i++) begin
			p0[i] = $signed(pts[32*i +: 32]);
			p1[i] = $signed(pts[32*(3+i) +: 32]);
			p2[i] = $signed(pts[32*(6+i) +: 32]);
			v0[i] = p0[i] - p1[i];
			v2[i] = p2[i] - p1[i];
		end
		vv0 = 0; vv2 = 0; v02 = 0;
		for (int i = 0; i < 3; i++) begin
			vv0 += 128'(v0[i]) * 128'(v0[i]);
			vv2 += 128'(v2[i]) * 128'(v2[i]);
			v02 += 128'(v0[i]) * 128'(v2[i]);
		end
		d = -3 * vv0; c = -v02; b = v02; a = 3 * vv2;
		tol3 = 3 * $signed({96'd0, tolerance});
		t48 = 0; half = 64'd1 << 47; stopped = 0;
		for (int i = 0; i < MAX_IT; i++) begin
			m = sar(d + 3 * c + 3 * b + a, 3);
			if (m >= tol3) begin
				b = sar(d + 2 * c + b, 2);
				c = sar(d + c, 1);
				a = m;
			end else if (m <= -tol3) begin
				c = sar(c + 2 * b + a, 2);
				b = sar(b + a, 1);
				d = m;
				t48 += half;
			end else begin
				stopped = 1;
				break;
			end
			half >>= 1;
		end
		if (!stopped) cap_count++;
		t48 += half;
		tq = (t48 + (64'd1 << 23)) >> 24;
		u = (64'd1 << 24) - tq;
		den = 2 * u * tq;
		f.degen = 0;
		for (int i = 0; i < 3; i++) begin
			num = (128'(p1[i]) <<< 48) - $signed({64'd0, u * u}) * 128'(p0[i])
				- $signed({64'd0, tq * tq}) * 128'(p2[i]);
			if (i == 0) f.cx = divide_axis(num, den, f.degen);
			if (i == 1) f.cy = divide_axis(num, den, f.degen);
			if (i == 2) f.cz = divide_axis(num, den, f.degen);
		end
		f.t = tq[24:0];
		return f;
	endfunction

	function automatic logic [287:0] pack_points(logic [31:0] v[9]);
		logic [287:0] r;
		for (int i = 0; i < 9; i++) r[32*i +: 32] = v[i];
		return r;
	endfunction

	// Random coordinate: mostly moderate values, sometimes full range or extremes.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
			2, 3: return $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
			default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic logic [287:0] rand_points();
		logic [31:0] v[9];
		int shape;
		for (int i = 0; i < 9; i++) v[i] = rand_coord();
		shape = $urandom_range(0, 9);
		// Some triples put the middle point on or near an end, pushing t towards 0 or 1; some make all points coincide.
		if (shape == 0) for (int i = 0; i < 3; i++) v[3+i] = v[i];
		if (shape == 1) for (int i = 0; i < 3; i++) v[3+i] = v[6+i];
		if (shape == 2) for (int i = 0; i < 3; i++) v[3+i] = v[i] + $urandom_range(0, 3);
		if (shape == 3) for (int i = 0; i < 9; i++) v[i] = v[i % 3];
		return pack_points(v);
	endfunction

	task automatic write_tolerance(logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tolerance = value;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic wait_drained();
		while (expected_fits.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic send_points(logic [287:0] pts);
		if (!send_noidle && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 14)) @(negedge clk);
		else
			@(negedge clk);
		s_tvalid <= 1;
		s_tdata <= pts;
		do @(posedge clk); while (!s_tready);
		expected_fits.push_back(predict_fit(pts));
		@(negedge clk);
		s_tvalid <= 0;
	endtask

	// Receiver: random stall bursts, one long hold-off on request, none in the quiet tail.
	initial begin
		forever begin
			@(negedge clk);
			if (recv_hold) begin
				// The receiver times the long hold-off itself so the sender can keep offering.
				m_tready <= 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				recv_hold = 0;
				m_tready <= 1;
			end else if (!recv_noidle && $urandom_range(0, 7) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				m_tready <= 1;
			end else m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		fit_t got, want;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
		if (m_tvalid && m_tready) begin
			got.cx = m_tdata[31:0];
			got.cy = m_tdata[63:32];
			got.cz = m_tdata[95:64];
			got.t = m_tdata[120:96];
			got.degen = m_tuser;
			fits_seen++;
			if (got.degen) degen_count++;
			if (expected_fits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat: %p", got);
			end else begin
				want = expected_fits.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk)
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results pending", expected_fits.size());
			$display("testbench: FAIL");
			$finish;
		end

	initial begin
		row_t rows[$];
		row_t r;
		logic [31:0] v[9];
		logic [31:0] tol_list[4];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed rows. Coincident points: bisection stops at once, t = 1/2, B = P1.
		for (int i = 0; i < 9; i++) v[i] = 32'h0001_0000;
		r.pts = pack_points(v); r.known = 1;
		r.res = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, T_HALF, 1'b0};
		rows.push_back(r);
		for (int i = 0; i < 9; i++) v[i] = POS_MAX;
		r.pts = pack_points(v);
		r.res = '{POS_MAX, POS_MAX, POS_MAX, T_HALF, 1'b0};
		rows.push_back(r);
		for (int i = 0; i < 9; i++) v[i] = NEG_MAX;
		r.pts = pack_points(v);
		r.res = '{NEG_MAX, NEG_MAX, NEG_MAX, T_HALF, 1'b0};
		rows.push_back(r);
		for (int i = 0; i < 9; i++) v[i] = 0;
		r.pts = pack_points(v);
		r.res = '{0, 0, 0, T_HALF, 1'b0};
		rows.push_back(r);
		// Remaining directed rows go through the predictor.
		r.known = 0;
		for (int k = 0; k < 16; k++) begin
			for (int i = 0; i < 9; i++)
				case (k % 4)
					0: v[i] = (i % 2) ? POS_MAX : NEG_MAX;
					1: v[i] = (i < 3) ? NEG_MAX : (i < 6 ? 32'd0 : POS_MAX);
					2: v[i] = (i < 6) ? POS_MAX : NEG_MAX;
					default: v[i] = $urandom();
				endcase
			if (k >= 8) for (int i = 0; i < 3; i++) v[3+i] = (k < 12) ? v[i] : v[6+i];
			r.pts = pack_points(v);
			rows.push_back(r);
		end
		r.pts = '1; rows.push_back(r);
		r.pts = {9{32'h5555_5555}}; rows.push_back(r);
		r.pts = {9{32'hAAAA_AAAA}}; rows.push_back(r);

		foreach (rows[k]) begin
			send_points(rows[k].pts);
			if (rows[k].known) begin
				void'(expected_fits.pop_back());
				expected_fits.push_back(rows[k].res);
			end
		end
		wait_drained();

		// Several tolerance settings including both extremes, random traffic under each.
		tol_list = '{32'd0, 32'hFFFF_FFFF, $urandom(), TOL_DEFAULT};
		for (int ph = 0; ph < 4; ph++) begin
			write_tolerance(tol_list[ph]);
			if (ph == 0) begin
				// Zero tolerance never stops early, so coincident points run to the cap.
				for (int i = 0; i < 9; i++) v[i] = 32'h0003_0000;
				send_points(pack_points(v));
			end
			if (ph == 1) begin
				// Hold the receiver off long enough for the block to back up.
				recv_hold = 1;
				for (int k = 0; k < 6; k++) send_points(rand_points());
			end
			if (ph == 3) recv_noidle = 0;
			for (int k = 0; k < N_RANDOM / 4; k++) begin
				if (ph == 3 && k == N_RANDOM / 8) begin
					recv_noidle = 1;
					send_noidle = 1;
				end
				send_points(rand_points());
			end
			// Sender pauses until everything has come back.
			wait_drained();
		end

		$display("covered %0d results over 4 tolerance settings, %0d degenerate, %0d hit the cap",
			fits_seen, degen_count, cap_count);
		if (mismatches == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
hdl/qbf_pkg.sv
hdl/qbf_front.sv
hdl/qbf_queue.sv
hdl/qbf_back.sv
hdl/quadratic_bezier_through_point_fit_unit.sv
hdl/qbf_checker.sv
bench/testbench.sv
